FILE: design/tbt_pkg.sv
// Shared types and constants for the touch baseline tracker.
// Used by tbt_lane, tbt_merge and touch_baseline_tracker; no dependencies.
package tbt_pkg;

    localparam int PADS    = 4;
    localparam int RAW_W   = 16;
    localparam int SUM_W   = 24;
    localparam int RATIO_W = 24;
    localparam int ALPHA_W = 17;
    localparam int CNT_W   = 8;
    localparam int PROD_W  = RAW_W + ALPHA_W;
    localparam int THRP_W  = RAW_W + RATIO_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    localparam logic [1:0] CFG_BUTTON_MASK = 2'd0;
    localparam logic [1:0] CFG_THRESH      = 2'd1;
    localparam logic [1:0] CFG_ALPHA       = 2'd2;
    localparam logic [1:0] CFG_FLOOR       = 2'd3;

    localparam logic [3:0]         RST_BUTTON_MASK = 4'd14;
    localparam logic [RATIO_W-1:0] RST_THRESH      = RATIO_W'(14260634);
    localparam logic [ALPHA_W-1:0] RST_ALPHA       = ALPHA_W'(3277);
    localparam logic [RAW_W-1:0]   RST_FLOOR       = RAW_W'(20);

    typedef enum logic [1:0] {
        STAT_CALIB  = 2'd0,
        STAT_DONE   = 2'd1,
        STAT_DETECT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_PRIME,
        PH_CALIB,
        PH_DETECT
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BASE,
        ST_MUL,
        ST_ACC,
        ST_THR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_sum;
        logic add_sum;
        logic div_load;
        logic div_step;
        logic base_load;
        logic det_load;
        logic ema_mul;
        logic ema_acc;
        logic thr_load;
    } ctl_t;

endpackage

FILE: design/tbt_lane.sv
// One pad lane: calibration sum, reciprocal-multiply mean, EMA baseline and threshold.
// Depends on tbt_pkg; driven by the control struct from touch_baseline_tracker.
module tbt_lane #(
    parameter int CALIB_SAMPLES = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tbt_pkg::ctl_t                 ctl,
    input  logic                          button,
    input  logic [tbt_pkg::RAW_W-1:0]     raw,
    input  logic [tbt_pkg::RATIO_W-1:0]   ratio,
    input  logic [tbt_pkg::ALPHA_W-1:0]   alpha,
    input  logic [tbt_pkg::RAW_W-1:0]     floor_level,
    output logic                          hit,
    output logic                          fault,
    output logic [tbt_pkg::RAW_W-1:0]     baseline
);

    localparam int SHIFT   = tbt_pkg::SUM_W + $clog2(CALIB_SAMPLES);
    localparam int QPROD_W = tbt_pkg::SUM_W + SHIFT;
    localparam logic [tbt_pkg::SUM_W:0] RECIP = (tbt_pkg::SUM_W + 1)'(
        ((64'd1 << SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

    logic [tbt_pkg::SUM_W-1:0]   sum_reg;
    logic [tbt_pkg::SUM_W-1:0]   sum_add;
    logic [tbt_pkg::SUM_W-1:0]   dvd_reg;
    logic [QPROD_W-1:0]          quot_prod;
    logic [tbt_pkg::RAW_W-1:0]   baseline_reg;
    logic [tbt_pkg::RAW_W-1:0]   threshold_reg;
    logic [tbt_pkg::RAW_W-1:0]   raw_reg;
    logic                        hit_reg;
    logic [tbt_pkg::ALPHA_W-1:0] alpha_sat;
    logic [tbt_pkg::PROD_W-1:0]  prod_old_reg;
    logic [tbt_pkg::PROD_W-1:0]  prod_new_reg;
    logic [tbt_pkg::PROD_W:0]    ema_sum;
    logic [tbt_pkg::THRP_W-1:0]  thr_prod;

    assign sum_add   = sum_reg + tbt_pkg::SUM_W'(raw);
    assign quot_prod = QPROD_W'(dvd_reg) * QPROD_W'(RECIP);
    assign alpha_sat = (alpha > tbt_pkg::ALPHA_ONE) ? tbt_pkg::ALPHA_ONE : alpha;
    assign ema_sum   = (tbt_pkg::PROD_W + 1)'(prod_old_reg)
                     + (tbt_pkg::PROD_W + 1)'(prod_new_reg);
    assign thr_prod  = tbt_pkg::THRP_W'(baseline_reg) * tbt_pkg::THRP_W'(ratio);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            baseline_reg  <= '0;
            threshold_reg <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (ctl.clear_sum)
            begin
                sum_reg <= '0;
                hit_reg <= 1'b0;
            end
            else if (ctl.add_sum)
            begin
                sum_reg <= sum_add;
                hit_reg <= 1'b0;
            end
            if (ctl.det_load)
            begin
                hit_reg <= button ? (raw == '0) : (raw < threshold_reg);
            end
            if (ctl.base_load)
            begin
                baseline_reg <= button ? '0 : dvd_reg[tbt_pkg::RAW_W-1:0];
            end
            if (ctl.ema_acc)
            begin
                if (button)
                begin
                    baseline_reg <= '0;
                end
                else if (!hit_reg)
                begin
                    baseline_reg <= ema_sum[tbt_pkg::RAW_W+15:16];
                end
            end
            if (ctl.thr_load)
            begin
                if (button)
                begin
                    threshold_reg <= '0;
                end
                else if (!hit_reg)
                begin
                    threshold_reg <= thr_prod[tbt_pkg::THRP_W-1:tbt_pkg::RATIO_W];
                end
            end
        end
    end

    // mean by reciprocal multiply, exact for every 24-bit sum; also holds raw sample and EMA products
    always_ff @(posedge clk)
    begin
        if (ctl.div_load)
        begin
            dvd_reg <= sum_add;
        end
        else if (ctl.div_step)
        begin
            dvd_reg <= quot_prod[SHIFT +: tbt_pkg::SUM_W];
        end
        if (ctl.det_load)
        begin
            raw_reg <= raw;
        end
        if (ctl.ema_mul)
        begin
            prod_old_reg <= tbt_pkg::PROD_W'(tbt_pkg::ALPHA_ONE - alpha_sat)
                          * tbt_pkg::PROD_W'(baseline_reg);
            prod_new_reg <= tbt_pkg::PROD_W'(alpha_sat) * tbt_pkg::PROD_W'(raw_reg);
        end
    end

    assign hit      = hit_reg;
    assign fault    = !button && (dvd_reg[tbt_pkg::RAW_W-1:0] < floor_level);
    assign baseline = baseline_reg;

endmodule

FILE: design/tbt_merge.sv
// Merge stage and output register: combines lane results into one transaction.
// Depends on tbt_pkg; instantiated by touch_baseline_tracker.
module tbt_merge (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       load,
    input  tbt_pkg::status_t                           status_in,
    input  logic [tbt_pkg::PADS-1:0]                   fault_in,
    input  logic [tbt_pkg::PADS-1:0]                   hit_in,
    input  logic [tbt_pkg::PADS-1:0]                   button_in,
    input  logic [tbt_pkg::PADS-1:0][tbt_pkg::RAW_W-1:0] base_in,
    input  logic                                       out_ready,
    output logic                                       out_valid,
    output logic                                       free,
    output logic [tbt_pkg::PADS-1:0]                   touched_out,
    output logic [1:0]                                 status_out,
    output logic [tbt_pkg::PADS-1:0]                   fault_out,
    output logic [tbt_pkg::PADS-1:0][tbt_pkg::RAW_W-1:0] base_out
);

    logic                                         valid_reg;
    logic [tbt_pkg::PADS-1:0]                     touched_reg;
    logic [1:0]                                   status_reg;
    logic [tbt_pkg::PADS-1:0]                     fault_reg;
    logic [tbt_pkg::PADS-1:0][tbt_pkg::RAW_W-1:0] base_reg;

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            touched_reg <= (status_in == tbt_pkg::STAT_DETECT) ? hit_in : '0;
            status_reg  <= status_in;
            fault_reg   <= fault_in;
            for (int n = 0; n < tbt_pkg::PADS; n++)
            begin
                base_reg[n] <= button_in[n] ? '0 : base_in[n];
            end
        end
    end

    assign out_valid   = valid_reg;
    assign touched_out = touched_reg;
    assign status_out  = status_reg;
    assign fault_out   = fault_reg;
    assign base_out    = base_reg;

endmodule

FILE: design/touch_baseline_tracker.sv
// Touch baseline tracker top level: control FSM, config registers, four pad lanes.
// Restart, priming and calibration scans go straight to the output load state;
// detection scans pass MUL, ACC and THR, the completing calibration scan DIV, BASE, THR.
// A new scan is taken once the result has moved into the output register; a full
// output register holds the FSM until it frees. Reset: config to defaults, priming
// scan pending, sums and baselines zero.
module touch_baseline_tracker #(
    parameter int CALIB_SAMPLES = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [tbt_pkg::RATIO_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [15:0]                   pad0_raw,
    input  logic [15:0]                   pad1_raw,
    input  logic [15:0]                   pad2_raw,
    input  logic [15:0]                   pad3_raw,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    touched_pads,
    output logic [1:0]                    status,
    output logic [3:0]                    wiring_fault_mask,
    output logic [15:0]                   pad0_baseline,
    output logic [15:0]                   pad1_baseline,
    output logic [15:0]                   pad2_baseline,
    output logic [15:0]                   pad3_baseline
);

    logic [3:0]                       button_mask_reg;
    logic [tbt_pkg::RATIO_W-1:0]      ratio_reg;
    logic [tbt_pkg::ALPHA_W-1:0]      alpha_reg;
    logic [tbt_pkg::RAW_W-1:0]        floor_reg;

    tbt_pkg::state_t                  state_reg, state_next;
    tbt_pkg::phase_t                  phase_reg;
    tbt_pkg::status_t                 status_reg;
    logic [tbt_pkg::CNT_W-1:0]        scan_count_reg;
    logic [tbt_pkg::PADS-1:0]         fault_reg;

    tbt_pkg::ctl_t                    ctl;
    logic                             accept;
    logic                             complete;
    logic                             out_load;
    logic                             out_free;

    logic [tbt_pkg::PADS-1:0][tbt_pkg::RAW_W-1:0] raw_vec;
    logic [tbt_pkg::PADS-1:0][tbt_pkg::RAW_W-1:0] base_vec;
    logic [tbt_pkg::PADS-1:0][tbt_pkg::RAW_W-1:0] base_out;
    logic [tbt_pkg::PADS-1:0]                     hit_vec;
    logic [tbt_pkg::PADS-1:0]                     lane_fault;

    assign raw_vec  = {pad3_raw, pad2_raw, pad1_raw, pad0_raw};
    assign accept   = (state_reg == tbt_pkg::ST_IDLE) && in_valid;
    assign complete = ({1'b0, scan_count_reg} + 1'b1)
                      >= (tbt_pkg::CNT_W + 1)'(CALIB_SAMPLES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_mask_reg <= tbt_pkg::RST_BUTTON_MASK;
            ratio_reg       <= tbt_pkg::RST_THRESH;
            alpha_reg       <= tbt_pkg::RST_ALPHA;
            floor_reg       <= tbt_pkg::RST_FLOOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbt_pkg::CFG_BUTTON_MASK: button_mask_reg <= cfg_data[3:0];
                tbt_pkg::CFG_THRESH:      ratio_reg <= cfg_data;
                tbt_pkg::CFG_ALPHA:       alpha_reg <= cfg_data[tbt_pkg::ALPHA_W-1:0];
                tbt_pkg::CFG_FLOOR:       floor_reg <= cfg_data[tbt_pkg::RAW_W-1:0];
                default:                  floor_reg <= floor_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action)
                        state_next = tbt_pkg::ST_OUT;
                    else if (phase_reg == tbt_pkg::PH_DETECT)
                        state_next = tbt_pkg::ST_MUL;
                    else if (phase_reg == tbt_pkg::PH_CALIB && complete)
                        state_next = tbt_pkg::ST_DIV;
                    else
                        state_next = tbt_pkg::ST_OUT;
                end
            end
            tbt_pkg::ST_DIV:  state_next = tbt_pkg::ST_BASE;
            tbt_pkg::ST_BASE: state_next = tbt_pkg::ST_THR;
            tbt_pkg::ST_MUL:  state_next = tbt_pkg::ST_ACC;
            tbt_pkg::ST_ACC:  state_next = tbt_pkg::ST_THR;
            tbt_pkg::ST_THR:  state_next = tbt_pkg::ST_OUT;
            tbt_pkg::ST_OUT:  state_next = out_free ? tbt_pkg::ST_IDLE : tbt_pkg::ST_OUT;
            default:          state_next = tbt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        out_load = 1'b0;
        in_ready = 1'b0;
        case (state_reg)
            tbt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action || phase_reg == tbt_pkg::PH_PRIME)
                    begin
                        ctl.clear_sum = 1'b1;
                    end
                    else if (phase_reg == tbt_pkg::PH_CALIB)
                    begin
                        ctl.add_sum  = 1'b1;
                        ctl.div_load = complete;
                    end
                    else
                    begin
                        ctl.det_load = 1'b1;
                    end
                end
            end
            tbt_pkg::ST_DIV:  ctl.div_step = 1'b1;
            tbt_pkg::ST_BASE:
            begin
                ctl.base_load = 1'b1;
                ctl.clear_sum = 1'b1;
            end
            tbt_pkg::ST_MUL:  ctl.ema_mul  = 1'b1;
            tbt_pkg::ST_ACC:  ctl.ema_acc  = 1'b1;
            tbt_pkg::ST_THR:  ctl.thr_load = 1'b1;
            tbt_pkg::ST_OUT:  out_load     = out_free;
            default:          out_load     = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tbt_pkg::ST_IDLE;
            phase_reg      <= tbt_pkg::PH_PRIME;
            status_reg     <= tbt_pkg::STAT_CALIB;
            scan_count_reg <= '0;
            fault_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (action)
                begin
                    phase_reg      <= tbt_pkg::PH_PRIME;
                    scan_count_reg <= '0;
                    fault_reg      <= '0;
                    status_reg     <= tbt_pkg::STAT_CALIB;
                end
                else
                begin
                    case (phase_reg)
                        tbt_pkg::PH_PRIME:
                        begin
                            phase_reg      <= tbt_pkg::PH_CALIB;
                            scan_count_reg <= '0;
                            status_reg     <= tbt_pkg::STAT_CALIB;
                        end
                        tbt_pkg::PH_CALIB:
                        begin
                            if (complete)
                            begin
                                phase_reg      <= tbt_pkg::PH_DETECT;
                                scan_count_reg <= '0;
                                status_reg     <= tbt_pkg::STAT_DONE;
                            end
                            else
                            begin
                                scan_count_reg <= scan_count_reg + 1'b1;
                                status_reg     <= tbt_pkg::STAT_CALIB;
                            end
                        end
                        default:  status_reg <= tbt_pkg::STAT_DETECT;
                    endcase
                end
            end
            if (ctl.base_load)
            begin
                fault_reg <= lane_fault;
            end
        end
    end

    for (genvar n = 0; n < tbt_pkg::PADS; n++)
    begin : g_lane
        tbt_lane #(
            .CALIB_SAMPLES (CALIB_SAMPLES)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .button      (button_mask_reg[n]),
            .raw         (raw_vec[n]),
            .ratio       (ratio_reg),
            .alpha       (alpha_reg),
            .floor_level (floor_reg),
            .hit         (hit_vec[n]),
            .fault       (lane_fault[n]),
            .baseline    (base_vec[n])
        );
    end

    tbt_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .status_in   (status_reg),
        .fault_in    (fault_reg),
        .hit_in      (hit_vec),
        .button_in   (button_mask_reg),
        .base_in     (base_vec),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .free        (out_free),
        .touched_out (touched_pads),
        .status_out  (status),
        .fault_out   (wiring_fault_mask),
        .base_out    (base_out)
    );

    assign pad0_baseline = base_out[0];
    assign pad1_baseline = base_out[1];
    assign pad2_baseline = base_out[2];
    assign pad3_baseline = base_out[3];

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action |=> phase_reg == tbt_pkg::PH_PRIME && fault_reg == '0)
        else $error("restart did not return to priming with faults cleared");

    a_done_in_detect: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg == tbt_pkg::STAT_DONE |-> phase_reg == tbt_pkg::PH_DETECT)
        else $error("calibration done reported outside detection phase");

    a_base_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tbt_pkg::ST_BASE |-> $past(state_reg) == tbt_pkg::ST_DIV)
        else $error("baseline load without a finished division");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid || out_ready)
        else $error("output register overwritten while a transaction is pending");

endmodule

FILE: test/tb.sv
// Testbench for touch_baseline_tracker: directed and random pad scans, each report
// checked against a scoreboard class that tracks calibration, baselines and thresholds.
// Depends on tbt_pkg and the touch_baseline_tracker RTL.
module tb;

    localparam int CALIB_N     = 50;
    localparam int HALF        = 6;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_SCANS = 130;
    localparam int SETTLE      = 40;

    typedef logic [tbt_pkg::PADS-1:0][tbt_pkg::RAW_W-1:0] scan_t;

    typedef struct packed {
        logic [3:0]                                   touched;
        tbt_pkg::status_t                             stat;
        logic [3:0]                                   faults;
        logic [tbt_pkg::PADS-1:0][tbt_pkg::RAW_W-1:0] base;
    } report_t;

    class scan_scoreboard;
        logic [3:0]                  btn_mask;
        logic [tbt_pkg::RATIO_W-1:0] ratio;
        logic [tbt_pkg::ALPHA_W-1:0] alpha;
        logic [tbt_pkg::RAW_W-1:0]   base_floor;
        tbt_pkg::phase_t             phase;
        logic [tbt_pkg::CNT_W-1:0]   scans;
        logic [tbt_pkg::SUM_W-1:0]   sum [tbt_pkg::PADS];
        logic [tbt_pkg::RAW_W-1:0]   base [tbt_pkg::PADS];
        logic [tbt_pkg::RAW_W-1:0]   thr [tbt_pkg::PADS];
        logic [3:0]                  faults;
        report_t                     reports [$];
        int                          errors;
        int                          checked;
        int                          calibrations;
        int                          touches;

        function new();
            btn_mask = tbt_pkg::RST_BUTTON_MASK;
            ratio = tbt_pkg::RST_THRESH;
            alpha = tbt_pkg::RST_ALPHA;
            base_floor = tbt_pkg::RST_FLOOR;
            phase = tbt_pkg::PH_PRIME;
            scans = '0;
            faults = '0;
            foreach (sum[n])
            begin
                sum[n] = '0;
                base[n] = '0;
                thr[n] = '0;
            end
            errors = 0;
            checked = 0;
            calibrations = 0;
            touches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [tbt_pkg::RATIO_W-1:0] value);
            case (idx)
                tbt_pkg::CFG_BUTTON_MASK: btn_mask = value[3:0];
                tbt_pkg::CFG_THRESH:      ratio = value;
                tbt_pkg::CFG_ALPHA:       alpha = value[tbt_pkg::ALPHA_W-1:0];
                tbt_pkg::CFG_FLOOR:       base_floor = value[tbt_pkg::RAW_W-1:0];
                default:                  base_floor = base_floor;
            endcase
        endfunction

        function logic [tbt_pkg::RAW_W-1:0] thresh_of(logic [tbt_pkg::RAW_W-1:0] b);
            logic [tbt_pkg::THRP_W-1:0] p;
            p = tbt_pkg::THRP_W'(b) * tbt_pkg::THRP_W'(ratio);
            return p[tbt_pkg::THRP_W-1:tbt_pkg::RATIO_W];
        endfunction

        // Predicts the report for one accepted scan transaction.
        function void note_scan(logic act, scan_t raw);
            report_t                     r;
            logic [tbt_pkg::ALPHA_W-1:0] a;
            logic [33:0]                 acc;
            r.touched = '0;
            r.stat = tbt_pkg::STAT_CALIB;
            if (act)
            begin
                phase = tbt_pkg::PH_PRIME;
                scans = '0;
                faults = '0;
                foreach (sum[n])
                    sum[n] = '0;
            end
            else if (phase == tbt_pkg::PH_PRIME)
            begin
                phase = tbt_pkg::PH_CALIB;
                scans = '0;
                foreach (sum[n])
                    sum[n] = '0;
            end
            else if (phase == tbt_pkg::PH_CALIB)
            begin
                foreach (sum[n])
                    sum[n] = sum[n] + tbt_pkg::SUM_W'(raw[n]);
                scans = scans + 1'b1;
                if (scans >= CALIB_N)
                begin
                    faults = '0;
                    foreach (sum[n])
                    begin
                        if (btn_mask[n])
                        begin
                            base[n] = '0;
                            thr[n] = '0;
                        end
                        else
                        begin
                            base[n] = tbt_pkg::RAW_W'(sum[n] / CALIB_N);
                            thr[n] = thresh_of(base[n]);
                            if (base[n] < base_floor)
                                faults[n] = 1'b1;
                        end
                        sum[n] = '0;
                    end
                    scans = '0;
                    phase = tbt_pkg::PH_DETECT;
                    r.stat = tbt_pkg::STAT_DONE;
                    calibrations++;
                end
            end
            else
            begin
                a = (alpha > tbt_pkg::ALPHA_ONE) ? tbt_pkg::ALPHA_ONE : alpha;
                r.stat = tbt_pkg::STAT_DETECT;
                foreach (base[n])
                begin
                    if (btn_mask[n])
                    begin
                        base[n] = '0;
                        thr[n] = '0;
                        if (raw[n] == '0)
                            r.touched[n] = 1'b1;
                    end
                    else if (raw[n] < thr[n])
                        r.touched[n] = 1'b1;
                    else
                    begin
                        acc = 34'(tbt_pkg::ALPHA_ONE - a) * 34'(base[n]) + 34'(a) * 34'(raw[n]);
                        base[n] = acc[31:16];
                        thr[n] = thresh_of(base[n]);
                    end
                end
                if (r.touched != '0)
                    touches++;
            end
            r.faults = faults;
            foreach (base[n])
                r.base[n] = btn_mask[n] ? '0 : base[n];
            reports.push_back(r);
        endfunction

        function void cmp_field(string name, logic [tbt_pkg::RAW_W-1:0] want,
                                logic [tbt_pkg::RAW_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(report_t got);
            report_t want;
            int      n;
            if (reports.size() == 0)
            begin
                errors++;
                $display("%0t: report with no scan pending: expected none, got touched %h status %0d",
                         $time, got.touched, got.stat);
                return;
            end
            want = reports.pop_front();
            checked++;
            cmp_field("touched_pads", want.touched, got.touched);
            cmp_field("status", want.stat, got.stat);
            cmp_field("wiring_fault_mask", want.faults, got.faults);
            for (n = 0; n < tbt_pkg::PADS; n++)
                cmp_field($sformatf("pad%0d_baseline", n), want.base[n], got.base[n]);
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [1:0]                  cfg_index = tbt_pkg::CFG_BUTTON_MASK;
    logic [tbt_pkg::RATIO_W-1:0] cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        action = 1'b0;
    logic [15:0]                 pad0_raw = '0;
    logic [15:0]                 pad1_raw = '0;
    logic [15:0]                 pad2_raw = '0;
    logic [15:0]                 pad3_raw = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [3:0]                  touched_pads;
    logic [1:0]                  status;
    logic [3:0]                  wiring_fault_mask;
    logic [15:0]                 pad0_baseline;
    logic [15:0]                 pad1_baseline;
    logic [15:0]                 pad2_baseline;
    logic [15:0]                 pad3_baseline;

    scan_scoreboard sb = new();
    int             send_pct = 32;
    int             recv_pct = 69;
    int             scans_sent = 0;
    int             quiet = 0;
    int             pad_level [tbt_pkg::PADS];

    // per-phase register settings; -1 picks a random value
    int set_mask  [9] = '{14, 0, 5, 10, 15, 3, 6, 0, -1};
    int set_ratio [9] = '{14260634, 16777215, 0, 12582912, -1, 14260634, 16000000, -1, 14260634};
    int set_alpha [9] = '{3277, 65536, 0, 131071, -1, 3277, 40000, -1, 1};
    int set_floor [9] = '{20, 0, 65535, 300, -1, 20, 100, 1000, 20};
    int set_recal [9] = '{1, 1, 1, 0, 1, 1, 0, 1, 1};

    touch_baseline_tracker #(
        .CALIB_SAMPLES (CALIB_N)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .pad0_raw          (pad0_raw),
        .pad1_raw          (pad1_raw),
        .pad2_raw          (pad2_raw),
        .pad3_raw          (pad3_raw),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .touched_pads      (touched_pads),
        .status            (status),
        .wiring_fault_mask (wiring_fault_mask),
        .pad0_baseline     (pad0_baseline),
        .pad1_baseline     (pad1_baseline),
        .pad2_baseline     (pad2_baseline),
        .pad3_baseline     (pad3_baseline)
    );

    always #HALF clk = ~clk;

    always @(negedge clk)
        out_ready = ($urandom_range(99) >= recv_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_report({touched_pads, status, wiring_fault_mask,
                             pad3_baseline, pad2_baseline, pad1_baseline, pad0_baseline});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_scan(input logic act, input scan_t raw);
        @(negedge clk);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        action = act;
        {pad3_raw, pad2_raw, pad1_raw, pad0_raw} = raw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_scan(act, raw);
        scans_sent++;
    endtask

    task automatic drain_reports();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value, input int width);
        int v;
        v = (value < 0) ? int'($urandom_range((1 << width) - 1)) : value;
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = tbt_pkg::RATIO_W'(v) | (tbt_pkg::RATIO_W'($urandom) << width);
        sb.set_reg(idx, cfg_data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [tbt_pkg::RAW_W-1:0] near(int level);
        int span;
        int v;
        span = level / 32 + 2;
        v = level - span + int'($urandom_range(2 * span));
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return tbt_pkg::RAW_W'(v);
    endfunction

    function automatic void pick_levels();
        foreach (pad_level[n])
            case ($urandom_range(3))
                0:       pad_level[n] = $urandom_range(60);
                1:       pad_level[n] = $urandom_range(65535);
                2:       pad_level[n] = 65535 - $urandom_range(3);
                default: pad_level[n] = $urandom_range(5000, 500);
            endcase
    endfunction

    function automatic scan_t make_scan();
        scan_t s;
        int    pick;
        foreach (pad_level[n])
        begin
            pick = $urandom_range(99);
            if (sb.phase != tbt_pkg::PH_DETECT)
                s[n] = (pick < 3) ? tbt_pkg::RAW_W'($urandom) : near(pad_level[n]);
            else if (pick < 12)
                s[n] = '0;
            else if (pick < 22)
                s[n] = tbt_pkg::RAW_W'(1);
            else if (pick < 34)
                s[n] = tbt_pkg::RAW_W'($urandom_range(pad_level[n] * 3 / 4));
            else if (pick < 42)
                s[n] = tbt_pkg::RAW_W'($urandom);
            else if (pick < 46)
                s[n] = sb.thr[n] - pick[0];
            else
                s[n] = near(pad_level[n]);
        end
        return s;
    endfunction

    task automatic directed_scans();
        send_scan(1'b1, '1);
        send_scan(1'b0, '0);
        send_scan(1'b0, '1);
        send_scan(1'b0, '0);
        send_scan(1'b1, {4{16'h5555}});
        send_scan(1'b0, {4{16'haaaa}});
        // pad 0 calibrates below the default floor
        repeat (CALIB_N) send_scan(1'b0, {16'd0, 16'd1, 16'hffff, 16'd10});
        send_scan(1'b0, '0);
        send_scan(1'b0, '1);
        send_scan(1'b0, {16'd2, 16'd1, 16'd0, sb.thr[0]});
        send_scan(1'b0, {16'hffff, 16'd0, 16'd1, sb.thr[0] - 1'b1});
        send_scan(1'b0, {4{16'h8000}});
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        directed_scans();
        for (int p = 0; p < 9; p++)
        begin
            if (p == 3)
            begin
                send_pct = 69;
                recv_pct = 32;
            end
            if (p == 6)
            begin
                send_pct = 0;
                recv_pct = 0;
            end
            drain_reports();
            write_reg(tbt_pkg::CFG_BUTTON_MASK, set_mask[p], 4);
            write_reg(tbt_pkg::CFG_THRESH, set_ratio[p], tbt_pkg::RATIO_W);
            write_reg(tbt_pkg::CFG_ALPHA, set_alpha[p], tbt_pkg::ALPHA_W);
            write_reg(tbt_pkg::CFG_FLOOR, set_floor[p], tbt_pkg::RAW_W);
            if (set_recal[p] != 0)
            begin
                pick_levels();
                send_scan(1'b1, scan_t'({$urandom, $urandom}));
            end
            repeat (PHASE_SCANS)
            begin
                if ($urandom_range(sb.phase == tbt_pkg::PH_DETECT ? 199 : 99) == 0)
                    send_scan(1'b1, scan_t'({$urandom, $urandom}));
                else
                    send_scan(1'b0, make_scan());
            end
        end
        drain_reports();
        $display("%0d scan transactions over 9 register settings, %0d reports checked",
                 scans_sent, sb.checked);
        $display("%0d calibrations completed, %0d reports with touches, %0d mismatches",
                 sb.calibrations, sb.touches, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
